FILE: rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// Clock tempo tracker package
// Shared constants, item and result layouts, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int DEFAULT_HISTORY_DEPTH = 8;

    localparam int CNT_W      = 31;
    localparam int SKIP_W     = 8;
    localparam int DIV_CNT_W  = 8;
    localparam int AVG_W      = 39;
    localparam int FILL_OUT_W = 4;
    localparam int FRAC_W     = 8;

    localparam logic [CNT_W:0] CNT_MAX = 32'h7FFF_FFFF;

    localparam logic                 RESET_ON_STOP_RESET = 1'b1;
    localparam logic [DIV_CNT_W-1:0] CLOCK_DIVIDE_RESET  = 8'd24;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_RESET_ON_STOP = 1'b0,
        REG_CLOCK_DIVIDE  = 1'b1
    } ctt_reg_idx_t;

    typedef struct packed {
        logic [SKIP_W-1:0] skipped;
        logic              continue_edge;
        logic              stop_edge;
        logic              start_edge;
        logic              divider_clear_edge;
        logic              clock_edge;
    } ctt_item_t;

    typedef struct packed {
        logic [FILL_OUT_W-1:0] history_fill;
        logic [AVG_W-1:0]      average_interval;
        logic                  period_updated;
        logic                  is_running;
        logic                  reset_pulse;
        logic                  clock_pulse;
    } ctt_result_t;

    typedef struct packed {
        logic load_item;
        logic hist_update;
        logic avg_start;
        logic avg_capture;
        logic mod_start;
        logic mod_capture;
        logic out_load;
    } ctt_cmd_t;

    typedef struct packed {
        logic item_clock;
        logic running;
        logic div_done;
    } ctt_stat_t;

endpackage

FILE: rtl/ctt_div.sv
// ----------------------------------------------------------------------------
// Clock tempo tracker divider
// Restoring divider that retires one quotient bit per cycle. The dividend is
// taken MSB first, so a short dividend is left-aligned and run for fewer
// iterations.
// ----------------------------------------------------------------------------
module ctt_div #(
    parameter int DIVIDEND_W = 42,
    parameter int DIVISOR_W  = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [DIVIDEND_W-1:0]             dividend,
    input  logic [DIVISOR_W-1:0]              divisor,
    input  logic [$clog2(DIVIDEND_W+1)-1:0]   iterations,
    output logic [DIVIDEND_W-1:0]             quotient,
    output logic [DIVISOR_W-1:0]              remainder,
    output logic                              done
);

    localparam int ITER_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    assign shifted = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            iter_next = iterations;
        end
        else if (iter_reg != '0)
        begin
            dvd_next  = {dvd_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? DIVISOR_W'(shifted - {1'b0, dsr_reg})
                             : DIVISOR_W'(shifted);
            iter_next = iter_reg - ITER_W'(1);
            done_next = (iter_reg == ITER_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign quotient  = dvd_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

FILE: rtl/ctt_datapath.sv
// ----------------------------------------------------------------------------
// Clock tempo tracker datapath
// Run flag and event logic, interval counter, interval history memory with a
// running sum, clock divider count, the shared divider and the result
// register.
// ----------------------------------------------------------------------------
module ctt_datapath #(
    parameter int HISTORY_DEPTH = ctt_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ctt_pkg::ctt_cmd_t                  cmd,
    output ctt_pkg::ctt_stat_t                 stat,
    input  ctt_pkg::ctt_item_t                 item,
    input  logic                               reset_on_stop,
    input  logic [ctt_pkg::DIV_CNT_W-1:0]      clock_divide,
    output ctt_pkg::ctt_result_t               result
);
    import ctt_pkg::*;

    localparam int PTR_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W      = CNT_W + ((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0);
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int ITER_W     = $clog2(DIVIDEND_W + 1);
    localparam int MOD_W      = DIV_CNT_W + 1;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [PTR_W-1:0]     wpos_reg, wpos_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 run_reg, run_next;
    logic [AVG_W-1:0]     avg_reg, avg_next;
    logic                 item_clock_reg, item_clock_next;
    logic                 rst_pulse_reg, rst_pulse_next;
    logic                 clk_pulse_reg, clk_pulse_next;
    ctt_result_t          result_reg;

    logic [CNT_W-1:0]     hist_mem [HISTORY_DEPTH];
    logic [CNT_W-1:0]     hist_rd_reg;

    logic                 start_hit;
    logic                 cnt_clear;
    logic [CNT_W-1:0]     cnt_base;
    logic [CNT_W:0]       cnt_trial;
    logic [CNT_W-1:0]     old_entry;

    logic                 div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIV_CNT_W-1:0] div_divisor;
    logic [ITER_W-1:0]    div_iters;
    logic [DIVIDEND_W-1:0] div_quotient;
    logic [DIV_CNT_W-1:0] div_remainder;
    logic                 div_done;
    logic [MOD_W-1:0]     div_cnt_inc;
    logic [DIV_CNT_W-1:0] ratio;

    assign start_hit = item.start_edge && !run_reg;
    assign cnt_clear = !run_reg && (item.start_edge || item.continue_edge);
    assign cnt_base  = cnt_clear ? '0 : cnt_reg;
    assign cnt_trial = {1'b0, cnt_base} + (CNT_W+1)'(item.skipped);
    assign old_entry = (fill_reg == FILL_W'(HISTORY_DEPTH)) ? hist_rd_reg : '0;

    assign div_cnt_inc = {1'b0, div_cnt_reg} + MOD_W'(1);
    assign ratio       = (clock_divide == '0) ? DIV_CNT_W'(1) : clock_divide;

    always_comb
    begin
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        fill_next       = fill_reg;
        wpos_next       = wpos_reg;
        div_cnt_next    = div_cnt_reg;
        run_next        = run_reg;
        avg_next        = avg_reg;
        item_clock_next = item_clock_reg;
        rst_pulse_next  = rst_pulse_reg;
        clk_pulse_next  = clk_pulse_reg;

        if (cmd.load_item)
        begin
            item_clock_next = item.clock_edge;
            clk_pulse_next  = 1'b0;
            rst_pulse_next  = start_hit || (item.stop_edge && reset_on_stop);
            if (item.stop_edge)
            begin
                run_next = 1'b0;
            end
            else if (item.start_edge || item.continue_edge)
            begin
                run_next = 1'b1;
            end
            if (cnt_trial < CNT_MAX)
            begin
                cnt_next = CNT_W'(cnt_trial + (CNT_W+1)'(1));
            end
            else
            begin
                cnt_next = cnt_base;
            end
            if (start_hit || item.divider_clear_edge)
            begin
                div_cnt_next = '0;
            end
        end

        if (cmd.hist_update)
        begin
            sum_next = sum_reg - SUM_W'(old_entry) + SUM_W'(cnt_reg);
            if (fill_reg != FILL_W'(HISTORY_DEPTH))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            wpos_next = (wpos_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wpos_reg + PTR_W'(1);
            cnt_next  = '0;
        end

        if (cmd.avg_capture)
        begin
            avg_next = AVG_W'(div_quotient);
        end

        if (cmd.mod_start)
        begin
            clk_pulse_next = (div_cnt_reg == '0);
        end

        if (cmd.mod_capture)
        begin
            div_cnt_next = div_remainder;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            sum_reg        <= '0;
            fill_reg       <= '0;
            wpos_reg       <= '0;
            div_cnt_reg    <= '0;
            run_reg        <= 1'b1;
            avg_reg        <= '0;
            item_clock_reg <= 1'b0;
            rst_pulse_reg  <= 1'b0;
            clk_pulse_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            sum_reg        <= sum_next;
            fill_reg       <= fill_next;
            wpos_reg       <= wpos_next;
            div_cnt_reg    <= div_cnt_next;
            run_reg        <= run_next;
            avg_reg        <= avg_next;
            item_clock_reg <= item_clock_next;
            rst_pulse_reg  <= rst_pulse_next;
            clk_pulse_reg  <= clk_pulse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_update)
        begin
            hist_mem[wpos_reg] <= cnt_reg;
        end
        if (cmd.load_item)
        begin
            hist_rd_reg <= hist_mem[wpos_reg];
        end
    end

    assign div_start    = cmd.avg_start || cmd.mod_start;
    assign div_dividend = cmd.avg_start ? {sum_reg, FRAC_W'(0)}
                                        : {div_cnt_inc, (DIVIDEND_W-MOD_W)'(0)};
    assign div_divisor  = cmd.avg_start ? DIV_CNT_W'(fill_reg) : ratio;
    assign div_iters    = cmd.avg_start ? ITER_W'(DIVIDEND_W) : ITER_W'(MOD_W);

    ctt_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (DIV_CNT_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend   (div_dividend),
        .divisor    (div_divisor),
        .iterations (div_iters),
        .quotient   (div_quotient),
        .remainder  (div_remainder),
        .done       (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.history_fill     <= FILL_OUT_W'(fill_reg);
            result_reg.average_interval <= avg_reg;
            result_reg.period_updated   <= item_clock_reg;
            result_reg.is_running       <= run_reg;
            result_reg.reset_pulse      <= rst_pulse_reg;
            result_reg.clock_pulse      <= clk_pulse_reg;
        end
    end

    assign result          = result_reg;
    assign stat.item_clock = item_clock_reg;
    assign stat.running    = run_reg;
    assign stat.div_done   = div_done;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HISTORY_DEPTH))
        else $error("History fill count exceeds the history depth.");

    a_wpos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= PTR_W'(HISTORY_DEPTH - 1))
        else $error("History write position is out of range.");

    a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_update |=> cnt_reg == '0)
        else $error("Interval counter did not restart after a history update.");

endmodule

FILE: rtl/ctt_ctrl.sv
// ----------------------------------------------------------------------------
// Clock tempo tracker controller
// Sequences one item at a time through event handling, history update, the
// average division and the divider count step, and owns the result valid.
// ----------------------------------------------------------------------------
module ctt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ctt_pkg::ctt_cmd_t  cmd,
    input  ctt_pkg::ctt_stat_t stat
);
    import ctt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIST,
        S_AVG_START,
        S_AVG_WAIT,
        S_MOD_START,
        S_MOD_WAIT,
        S_FINISH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_HIST:
            begin
                cmd.hist_update = 1'b1;
                state_next      = S_AVG_START;
            end
            S_AVG_START:
            begin
                cmd.avg_start = 1'b1;
                state_next    = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.avg_capture = 1'b1;
                    state_next      = stat.running ? S_MOD_START : S_DONE;
                end
            end
            S_MOD_START:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_MOD_WAIT;
            end
            S_MOD_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.mod_capture = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_FINISH:
            begin
                if (stat.item_clock)
                begin
                    state_next = S_HIST;
                end
                else if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("Result register loaded without raising its valid.");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("Result valid dropped before its transfer.");

    a_hist_on_clock: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_update |-> stat.item_clock)
        else $error("History updated for a tick without a clock edge.");

endmodule

FILE: rtl/clock_tempo_tracker_top.sv
// ----------------------------------------------------------------------------
// Clock tempo tracker
// Channel    Dir  Width  Contents
// s_axis     in   16     sample tick: edge flags and skipped-sample count
// m_axis     out  48     divided clock, reset pulse, run flag, mean interval
// apb        in   3/32   reset_on_stop at 0x0, clock_divide at 0x4
//
// A tick without a clock edge is registered, then moved to the output register.
// A tick with a clock edge also runs the bit-serial divider: the average
// takes SUM_W+8 iterations (42 at depth 8) and, while running, the divider
// count step takes 9 more. One tick is in work at a time; a finished result
// waits in the output register while the next tick is taken in. Reset is
// asynchronous, active low.
// ----------------------------------------------------------------------------
module clock_tempo_tracker_top #(
    parameter int HISTORY_DEPTH = ctt_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // clock_edge, divider_clear_edge, start_edge, stop_edge, continue_edge,
    // skipped[7:0], zero fill
    input  logic [ctt_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // clock_pulse, reset_pulse, is_running, period_updated,
    // average_interval[38:0], history_fill[3:0], zero fill
    output logic [ctt_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ctt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ctt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ctt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import ctt_pkg::*;

    localparam int ITEM_W   = $bits(ctt_item_t);
    localparam int RESULT_W = $bits(ctt_result_t);

    logic                 reset_on_stop_reg, reset_on_stop_next;
    logic [DIV_CNT_W-1:0] clock_divide_reg, clock_divide_next;
    logic                 cfg_write;
    ctt_reg_idx_t         reg_idx;

    ctt_cmd_t             cmd;
    ctt_stat_t            stat;
    ctt_item_t            item;
    ctt_result_t          result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = ctt_reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_comb
    begin
        reset_on_stop_next = reset_on_stop_reg;
        clock_divide_next  = clock_divide_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_RESET_ON_STOP: reset_on_stop_next = pwdata[0];
                REG_CLOCK_DIVIDE:  clock_divide_next  = pwdata[DIV_CNT_W-1:0];
                default:           reset_on_stop_next = reset_on_stop_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RESET_ON_STOP: prdata = APB_DATA_W'(reset_on_stop_reg);
            REG_CLOCK_DIVIDE:  prdata = APB_DATA_W'(clock_divide_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_on_stop_reg <= RESET_ON_STOP_RESET;
            clock_divide_reg  <= CLOCK_DIVIDE_RESET;
        end
        else
        begin
            reset_on_stop_reg <= reset_on_stop_next;
            clock_divide_reg  <= clock_divide_next;
        end
    end

    assign item    = ctt_item_t'(s_tdata[ITEM_W-1:0]);
    assign m_tdata = OUT_DATA_W'(result[RESULT_W-1:0]);

    ctt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ctt_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item          (item),
        .reset_on_stop (reset_on_stop_reg),
        .clock_divide  (clock_divide_reg),
        .result        (result)
    );

endmodule

FILE: dv/clock_tempo_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock tempo tracker checker
// Watches the tick and result streams and the register port, keeps its own
// model of the tracker state, and compares every result transfer field by
// field against the oldest predicted result. Reports a running mismatch count
// and the number of results still outstanding.
// ----------------------------------------------------------------------------
module clock_tempo_tracker_checker #(
    parameter int DEPTH = ctt_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ctt_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ctt_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ctt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ctt_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic                            pready,
    output int                              error_count,
    output int                              pending
);
    import ctt_pkg::*;

    logic                 stop_resets;
    logic [DIV_CNT_W-1:0] clk_ratio;

    logic [CNT_W-1:0]     interval_cnt;
    logic [CNT_W-1:0]     interval_hist [DEPTH];
    int unsigned          wr_pos;
    int unsigned          fill;
    logic [DIV_CNT_W-1:0] div_count;
    logic                 run_flag;
    logic [AVG_W-1:0]     avg_held;

    ctt_result_t          expected_q [$];

    task automatic advance_tick(input ctt_item_t t, output ctt_result_t r);
        logic [63:0]          total;
        int unsigned          k;
        logic [DIV_CNT_W-1:0] ratio;
        r = '0;
        if (t.start_edge && !run_flag) begin
            r.reset_pulse = 1'b1;
            div_count     = '0;
            interval_cnt  = '0;
            run_flag      = 1'b1;
        end
        if (t.continue_edge && !run_flag) begin
            interval_cnt = '0;
            run_flag     = 1'b1;
        end
        if (t.stop_edge) begin
            if (stop_resets)
                r.reset_pulse = 1'b1;
            run_flag = 1'b0;
        end
        if ({1'b0, interval_cnt} + 32'(t.skipped) < CNT_MAX)
            interval_cnt = interval_cnt + CNT_W'(t.skipped) + 1'b1;
        if (t.divider_clear_edge)
            div_count = '0;
        if (t.clock_edge) begin
            interval_hist[wr_pos] = interval_cnt;
            if (fill < DEPTH)
                fill++;
            total = '0;
            for (k = 0; k < fill; k++)
                total += 64'(interval_hist[(wr_pos + DEPTH - k) % DEPTH]);
            avg_held     = AVG_W'((total << FRAC_W) / 64'(fill));
            wr_pos       = (wr_pos + 1) % DEPTH;
            interval_cnt = '0;
            if (run_flag) begin
                ratio = (clk_ratio == 0) ? DIV_CNT_W'(1) : clk_ratio;
                if (div_count == 0)
                    r.clock_pulse = 1'b1;
                div_count = DIV_CNT_W'((int'(div_count) + 1) % int'(ratio));
            end
        end
        r.is_running       = run_flag;
        r.period_updated   = t.clock_edge;
        r.average_interval = avg_held;
        r.history_fill     = FILL_OUT_W'(fill);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got, inout int fails);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        ctt_result_t want;
        ctt_result_t got;
        int          fails;
        int unsigned k;
        if (!rst_n) begin
            stop_resets  = RESET_ON_STOP_RESET;
            clk_ratio    = CLOCK_DIVIDE_RESET;
            interval_cnt = '0;
            for (k = 0; k < DEPTH; k++)
                interval_hist[k] = '0;
            wr_pos    = 0;
            fill      = 0;
            div_count = '0;
            run_flag  = 1'b1;
            avg_held  = '0;
            expected_q.delete();
            error_count <= 0;
            pending     <= 0;
        end else begin
            fails = 0;
            if (psel && penable && pwrite && pready) begin
                case (ctt_reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_RESET_ON_STOP: stop_resets = pwdata[0];
                    REG_CLOCK_DIVIDE:  clk_ratio   = pwdata[DIV_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_tick(ctt_item_t'(s_tdata[$bits(ctt_item_t)-1:0]), want);
                expected_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = ctt_result_t'(m_tdata[$bits(ctt_result_t)-1:0]);
                if (expected_q.size() == 0) begin
                    $error("result transfer with no tick outstanding: %h", got);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("clock_pulse", want.clock_pulse, got.clock_pulse, fails);
                    check_field("reset_pulse", want.reset_pulse, got.reset_pulse, fails);
                    check_field("is_running", want.is_running, got.is_running, fails);
                    check_field("period_updated", want.period_updated,
                                got.period_updated, fails);
                    check_field("average_interval", want.average_interval,
                                got.average_interval, fails);
                    check_field("history_fill", want.history_fill, got.history_fill, fails);
                end
            end
            error_count <= error_count + fails;
            pending     <= expected_q.size();
        end
    end

endmodule

FILE: dv/clock_tempo_tracker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock tempo tracker testbench
// Drives sample ticks through the tracker under random source and sink
// idling: a directed set of edge combinations first, then random ticks over
// several divide ratios and stop behaviors, with one long sink hold-off that
// backs up the input. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module clock_tempo_tracker_top_tb;
    import ctt_pkg::*;

    localparam int RESET_CYCLES     = 7;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 230;
    localparam int SETTLE_CYCLES    = 10;
    localparam int END_CYCLES       = 100;
    localparam int STALL_LIMIT      = 3000;
    localparam int HOLD_AT_RESULT   = 400;
    localparam int HOLD_CYCLES      = 400;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int error_count;
    int pending;
    int ticks_sent;
    int clock_ticks_sent;
    int blocked_cycles;

    bit           stop_reset_set [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    int unsigned  ratio_set      [PHASES] = '{1, 255, 3, 0, 7, 24};

    always #6 clk = ~clk;

    clock_tempo_tracker_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    clock_tempo_tracker_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .error_count (error_count),
        .pending     (pending)
    );

    function automatic ctt_item_t make_tick(input bit clk_e, input bit clr_e, input bit start_e,
                                            input bit stop_e, input bit cont_e,
                                            input int unsigned skip);
        ctt_item_t t;
        t.clock_edge         = clk_e;
        t.divider_clear_edge = clr_e;
        t.start_edge         = start_e;
        t.stop_edge          = stop_e;
        t.continue_edge      = cont_e;
        t.skipped            = SKIP_W'(skip);
        return t;
    endfunction

    function automatic ctt_item_t random_tick();
        int unsigned skip;
        case ($urandom_range(0, 3))
            0:       skip = 0;
            1:       skip = 255;
            default: skip = $urandom_range(0, 255);
        endcase
        return make_tick($urandom_range(0, 2) == 0, $urandom_range(0, 31) == 0,
                         $urandom_range(0, 24) == 0, $urandom_range(0, 39) == 0,
                         $urandom_range(0, 24) == 0, skip);
    endfunction

    function automatic int draw_gap(input int index);
        if ((index / 64) % 3 == 2)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    task automatic send_tick(input ctt_item_t t);
        int gap;
        gap = draw_gap(ticks_sent);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= IN_DATA_W'(t);
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        ticks_sent++;
        if (t.clock_edge)
            clock_ticks_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ctt_reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : sink
        int gap;
        int taken;
        taken = 0;
        wait (rst_n);
        forever begin
            gap = (taken == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_gap(taken + 32);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        blocked_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (s_tvalid && !s_tready)
                blocked_cycles++;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("clock_tempo_tracker_top_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int p;
        int n;
        ticks_sent       = 0;
        clock_ticks_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(make_tick(0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 255));
        send_tick(make_tick(1, 0, 0, 0, 0, 255));
        send_tick(make_tick(1, 0, 0, 0, 0, 0));
        send_tick(make_tick(1, 1, 0, 0, 0, 17));
        send_tick(make_tick(0, 0, 0, 1, 0, 3));
        send_tick(make_tick(0, 0, 0, 1, 0, 0));
        send_tick(make_tick(1, 0, 0, 0, 0, 40));
        send_tick(make_tick(0, 0, 0, 0, 1, 5));
        send_tick(make_tick(0, 0, 0, 0, 1, 0));
        send_tick(make_tick(0, 0, 1, 0, 0, 9));
        send_tick(make_tick(1, 0, 1, 1, 0, 2));
        send_tick(make_tick(0, 0, 1, 0, 0, 0));
        send_tick(make_tick(0, 0, 1, 1, 0, 128));
        send_tick(make_tick(1, 0, 0, 1, 1, 64));
        send_tick(make_tick(1, 1, 1, 1, 1, 255));
        send_tick(make_tick(0, 0, 0, 0, 1, 0));
        for (n = 0; n < 8; n++)
            send_tick(make_tick(1, 0, 0, 0, 0, n * 37));

        for (p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_RESET_ON_STOP, APB_DATA_W'(stop_reset_set[p]));
            write_reg(REG_CLOCK_DIVIDE, APB_DATA_W'(ratio_set[p]));
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                send_tick(random_tick());
        end

        settle();
        repeat (END_CYCLES) @(posedge clk);
        $display("Sent %0d ticks, %0d of them with a clock edge, over %0d register settings.",
                 ticks_sent, clock_ticks_sent, PHASES + 1);
        $display("Input held back by a full block for %0d cycles.", blocked_cycles);
        if (error_count == 0)
            $display("clock_tempo_tracker_top_tb: clean");
        else
            $display("clock_tempo_tracker_top_tb: errors");
        $finish;
    end

endmodule
